// File: rtl/uvs_pkg.sv
// ============================================================================
// uvs_pkg: shared types and constants for the UV-sphere vertex generator
// Request formats, register codes, CORDIC arctangent table, fixed-point widths.
// ============================================================================
`default_nettype none

package uvs_pkg;

  // index and count width
  localparam int IDX_W = 8;

  // register map
  localparam int REG_IDX_W = 8;
  localparam logic [REG_IDX_W-1:0] REG_STACK_COUNT  = 8'd0;
  localparam logic [REG_IDX_W-1:0] REG_SECTOR_COUNT = 8'd1;
  localparam logic [IDX_W-1:0] STACK_COUNT_RESET  = 8'd16;
  localparam logic [IDX_W-1:0] SECTOR_COUNT_RESET = 8'd32;

  // phase is in units of 2^-32 turn; quotient keeps one integer bit
  localparam int PHASE_W = 32;
  localparam int QUO_W   = PHASE_W + 1;

  // CORDIC datapath: x/y in Q2.30 with headroom, angle residue in 2^-32 turn
  localparam int XY_W  = 34;
  localparam int ANG_W = 32;
  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032875;

  // quadrant codes (top two phase bits)
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  localparam int ATAN_LEN = 24;
  localparam logic signed [ANG_W-1:0] ATAN_TAB [ATAN_LEN] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
    32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
    32'sd652,       32'sd326,       32'sd163,       32'sd81
  };

  // output formats
  localparam int COORD_W = 16;
  localparam int RND_W   = 22;
  localparam int TEX_W   = 17;
  localparam logic signed [RND_W-1:0] COORD_MAX = 22'sd16384;
  localparam logic signed [RND_W-1:0] COORD_MIN = -22'sd16384;

  typedef struct packed {
    logic [IDX_W-1:0] stack_index;
    logic [IDX_W-1:0] sector_index;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic [TEX_W-1:0]          tex_u;
    logic [TEX_W-1:0]          tex_v;
    logic                      index_clamped;
  } out_item_t;

  // saturate a rounded coordinate to +-1.0 in Q1.14
  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [RND_W-1:0] v);
    logic signed [RND_W-1:0] t;
    begin
      t = v;
      if (v > COORD_MAX) t = COORD_MAX;
      else if (v < COORD_MIN) t = COORD_MIN;
      sat_coord = t[COORD_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// File: rtl/uvs_cordic.sv
// ============================================================================
// uvs_cordic: pipelined rotation-mode CORDIC
// One micro-rotation per stage; gives cos and sin in Q2.30 of a 32-bit phase.
// Load, rotation and fold registers; one phase per cycle while en is high.
// ============================================================================
`default_nettype none

module uvs_cordic #(
  parameter int STAGES = 16
) (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic [uvs_pkg::PHASE_W-1:0]       phase,
  output logic signed [uvs_pkg::XY_W-1:0]        cos_o,
  output logic signed [uvs_pkg::XY_W-1:0]        sin_o
);

  logic signed [uvs_pkg::XY_W-1:0]  x_r [STAGES+1];
  logic signed [uvs_pkg::XY_W-1:0]  y_r [STAGES+1];
  logic signed [uvs_pkg::ANG_W-1:0] z_r [STAGES+1];
  logic [1:0]                       quad_r [STAGES+1];
  logic signed [uvs_pkg::XY_W-1:0]  cos_r, sin_r;

  // load: start vector (K, 0), residue is the phase within the quadrant
  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= uvs_pkg::CORDIC_GAIN;
      y_r[0]    <= '0;
      z_r[0]    <= {2'b00, phase[uvs_pkg::PHASE_W-3:0]};
      quad_r[0] <= phase[uvs_pkg::PHASE_W-1:uvs_pkg::PHASE_W-2];
    end
  end

  // micro-rotation stages
  for (genvar k = 0; k < STAGES; k++) begin : g_rot
    logic signed [uvs_pkg::XY_W-1:0] dx, dy;
    logic                            pos;
    assign dx  = y_r[k] >>> k;
    assign dy  = x_r[k] >>> k;
    assign pos = ~z_r[k][uvs_pkg::ANG_W-1];
    always_ff @(posedge clk) begin
      if (en) begin
        x_r[k+1]    <= pos ? x_r[k] - dx : x_r[k] + dx;
        y_r[k+1]    <= pos ? y_r[k] + dy : y_r[k] - dy;
        z_r[k+1]    <= pos ? z_r[k] - uvs_pkg::ATAN_TAB[k] : z_r[k] + uvs_pkg::ATAN_TAB[k];
        quad_r[k+1] <= quad_r[k];
      end
    end
  end

  // quadrant fold
  always_ff @(posedge clk) begin
    if (en) begin
      unique case (quad_r[STAGES])
        uvs_pkg::QUAD_0: begin cos_r <= x_r[STAGES];  sin_r <= y_r[STAGES];  end
        uvs_pkg::QUAD_1: begin cos_r <= -y_r[STAGES]; sin_r <= x_r[STAGES];  end
        uvs_pkg::QUAD_2: begin cos_r <= -x_r[STAGES]; sin_r <= -y_r[STAGES]; end
        default:         begin cos_r <= y_r[STAGES];  sin_r <= -x_r[STAGES]; end
      endcase
    end
  end

  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule

`default_nettype wire

// File: rtl/uv_sphere_vertex_generator.sv
// ============================================================================
// uv_sphere_vertex_generator: UV-sphere vertex and texture coordinate pipeline
// Stack/sector index in, unit-sphere vertex (Q1.14) and UV (unsigned Q1.16) out.
// ============================================================================
// Takes one request per cycle while not stalled and returns one result per
// request, in order. The pipeline is an input clamp stage, two bit-per-stage
// dividers (33 stages each, forming the polar and azimuth phases), two CORDIC
// rotators (CORDIC_STAGES+2 stages), a split multiply, a rounding stage and
// the output register. The pipeline stalls as a whole only while a result
// sits in the output register and out_ready is low.
// Register writes are accepted at any time but must only be issued while
// idle; a count of zero acts as one and an index above its count is clamped
// and flagged.
`default_nettype none

module uv_sphere_vertex_generator #(
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire uvs_pkg::in_item_t             in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output uvs_pkg::out_item_t                 out_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [uvs_pkg::REG_IDX_W-1:0] cfg_index,
  input  wire logic [uvs_pkg::IDX_W-1:0]     cfg_data
);

  localparam int W       = uvs_pkg::IDX_W;
  localparam int QW      = uvs_pkg::QUO_W;
  localparam int COR_LAT = CORDIC_STAGES + 2;
  localparam int META_N  = COR_LAT + 2;
  localparam int LAT     = 1 + QW + COR_LAT + 3;

  typedef struct packed {
    logic [uvs_pkg::TEX_W-1:0] tex_u;
    logic [uvs_pkg::TEX_W-1:0] tex_v;
    logic                      clamped;
  } meta_t;

  // ---------------- configuration ----------------
  logic [W-1:0] stack_cnt_r, sector_cnt_r;
  logic [W-1:0] ns, nc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stack_cnt_r  <= uvs_pkg::STACK_COUNT_RESET;
      sector_cnt_r <= uvs_pkg::SECTOR_COUNT_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == uvs_pkg::REG_STACK_COUNT)  stack_cnt_r  <= cfg_data;
      if (cfg_index == uvs_pkg::REG_SECTOR_COUNT) sector_cnt_r <= cfg_data;
    end
  end

  assign ns = (stack_cnt_r == '0)  ? W'(1) : stack_cnt_r;
  assign nc = (sector_cnt_r == '0) ? W'(1) : sector_cnt_r;

  // ---------------- flow control ----------------
  logic           pipe_en;
  logic [LAT-1:0] vld_r;

  assign pipe_en   = ~vld_r[LAT-1] | out_ready;
  assign in_ready  = pipe_en;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (pipe_en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // ---------------- clamp ----------------
  logic [W-1:0] i_r, j_r;
  logic         clamp_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      i_r     <= (in_data.stack_index > ns)  ? ns : in_data.stack_index;
      j_r     <= (in_data.sector_index > nc) ? nc : in_data.sector_index;
      clamp_r <= (in_data.stack_index > ns) | (in_data.sector_index > nc);
    end
  end

  // ---------------- dividers: floor(idx * 2^32 / count) ----------------
  // stage 0 takes the integer bit (idx <= count), then one fraction bit a stage
  logic [W-1:0]  rem_i_r [QW];
  logic [W-1:0]  rem_j_r [QW];
  logic [QW-1:0] quo_i_r [QW];
  logic [QW-1:0] quo_j_r [QW];
  logic          clmp_d_r [QW];

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      rem_i_r[0]  <= (i_r == ns) ? '0 : i_r;
      rem_j_r[0]  <= (j_r == nc) ? '0 : j_r;
      quo_i_r[0]  <= QW'(i_r == ns);
      quo_j_r[0]  <= QW'(j_r == nc);
      clmp_d_r[0] <= clamp_r;
    end
  end

  for (genvar s = 1; s < QW; s++) begin : g_div
    logic [W:0] ri2, rj2;
    logic       gi, gj;
    assign ri2 = {rem_i_r[s-1], 1'b0};
    assign rj2 = {rem_j_r[s-1], 1'b0};
    assign gi  = ri2 >= {1'b0, ns};
    assign gj  = rj2 >= {1'b0, nc};
    always_ff @(posedge clk) begin
      if (pipe_en) begin
        rem_i_r[s]  <= gi ? W'(ri2 - {1'b0, ns}) : W'(ri2);
        rem_j_r[s]  <= gj ? W'(rj2 - {1'b0, nc}) : W'(rj2);
        quo_i_r[s]  <= {quo_i_r[s-1][QW-2:0], gi};
        quo_j_r[s]  <= {quo_j_r[s-1][QW-2:0], gj};
        clmp_d_r[s] <= clmp_d_r[s-1];
      end
    end
  end

  // ---------------- phases and texture coordinates ----------------
  logic [QW-1:0]               qi, qj;
  logic [uvs_pkg::PHASE_W-1:0] pol_ph, az_ph;
  logic [uvs_pkg::TEX_W:0]     tu_sum, tv_sum;
  meta_t                       meta_in;

  assign qi     = quo_i_r[QW-1];
  assign qj     = quo_j_r[QW-1];
  assign pol_ph = qi[QW-1:1];
  assign az_ph  = qj[uvs_pkg::PHASE_W-1:0];
  // round half up of idx*65536/count from floor(idx*2^17/count)
  assign tu_sum = qj[QW-1:15] + 18'd1;
  assign tv_sum = qi[QW-1:15] + 18'd1;
  assign meta_in = '{tex_u: tu_sum[uvs_pkg::TEX_W:1],
                     tex_v: tv_sum[uvs_pkg::TEX_W:1],
                     clamped: clmp_d_r[QW-1]};

  meta_t meta_r [META_N];

  always_ff @(posedge clk) begin
    if (pipe_en) meta_r[0] <= meta_in;
  end

  for (genvar m = 1; m < META_N; m++) begin : g_meta
    always_ff @(posedge clk) begin
      if (pipe_en) meta_r[m] <= meta_r[m-1];
    end
  end

  // ---------------- CORDIC ----------------
  logic signed [uvs_pkg::XY_W-1:0] cp, sp, ca, sa;

  uvs_cordic #(.STAGES(CORDIC_STAGES)) u_cor_pol (
    .clk   (clk),
    .en    (pipe_en),
    .phase (pol_ph),
    .cos_o (cp),
    .sin_o (sp)
  );

  uvs_cordic #(.STAGES(CORDIC_STAGES)) u_cor_az (
    .clk   (clk),
    .en    (pipe_en),
    .phase (az_ph),
    .cos_o (ca),
    .sin_o (sa)
  );

  // ---------------- split multiply: sin(polar) in two halves ----------------
  logic signed [17:0]                sp_hi;
  logic signed [16:0]                sp_lo;
  logic signed [51:0]                x_hh_r, y_hh_r;
  logic signed [50:0]                x_lh_r, y_lh_r;
  logic signed [uvs_pkg::XY_W-1:0]   cp_d_r;

  assign sp_hi = sp[uvs_pkg::XY_W-1:16];
  assign sp_lo = $signed({1'b0, sp[15:0]});

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      x_hh_r <= sp_hi * ca;
      y_hh_r <= sp_hi * sa;
      x_lh_r <= sp_lo * ca;
      y_lh_r <= sp_lo * sa;
      cp_d_r <= cp;
    end
  end

  // ---------------- recombine and round ----------------
  localparam logic signed [67:0] RND46 = 68'sd1 <<< 45;
  logic signed [67:0]               sx, sy;
  logic signed [uvs_pkg::XY_W:0]    sz;
  logic signed [uvs_pkg::RND_W-1:0] rx_r, ry_r, rz_r;

  assign sx = (68'(x_hh_r) <<< 16) + 68'(x_lh_r) + RND46;
  assign sy = (68'(y_hh_r) <<< 16) + 68'(y_lh_r) + RND46;
  assign sz = 35'(cp_d_r) + 35'sd32768;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      rx_r <= sx[67:46];
      ry_r <= sy[67:46];
      // sign-extend the shifted cosine
      rz_r <= uvs_pkg::RND_W'($signed(sz[uvs_pkg::XY_W:16]));
    end
  end

  // ---------------- saturate and output register ----------------
  uvs_pkg::out_item_t out_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      out_r.pos_x         <= uvs_pkg::sat_coord(rx_r);
      out_r.pos_y         <= uvs_pkg::sat_coord(ry_r);
      out_r.pos_z         <= uvs_pkg::sat_coord(rz_r);
      out_r.tex_u         <= meta_r[META_N-1].tex_u;
      out_r.tex_v         <= meta_r[META_N-1].tex_v;
      out_r.index_clamped <= meta_r[META_N-1].clamped;
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire
